// ===== src/assert_macros.svh =====
// Assertion helpers for the heap queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bmhq_pkg.sv =====
`default_nettype none
package bmhq_pkg;
    localparam int CAPACITY = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POP = 2'd1;
    localparam logic [1:0] KIND_FIND = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_PARENT,
        S_RD_AT,
        S_RD_L,
        S_RD_R,
        S_DECIDE,
        S_SWAP_A,
        S_SWAP_B,
        S_TOP_RD,
        S_TOP_WAIT,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== src/bmhq_if.sv =====
`default_nettype none
interface bmhq_req_if import bmhq_pkg::*; (input wire logic clk);
    logic valid;
    logic ready;
    logic [1:0] kind;
    value_t value;
    modport source (output valid, kind, value, input ready);
    modport sink (input valid, kind, value, output ready);
endinterface

interface bmhq_rsp_if import bmhq_pkg::*; (input wire logic clk);
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [5:0] found_index;
    value_t top_value;
    logic [6:0] count;
    modport source (output valid, status, found_index, top_value, count, input ready);
    modport sink (input valid, status, found_index, top_value, count, output ready);
endinterface
`default_nettype wire

// ===== src/bmhq_ram.sv =====
`default_nettype none
module bmhq_ram import bmhq_pkg::*; (
    input wire logic clk,
    input wire logic we,
    input wire idx_t waddr,
    input wire value_t wdata,
    input wire idx_t raddr,
    output value_t rdata
);
    value_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/binary_max_heap_queue.sv =====
// Signed max-heap queue of CAPACITY values, one response beat per request beat.
// The store is a single-port-read RAM served by one comparator under a sequencer,
// so value accesses are sequenced one at a time. Find reads and compares each scanned
// entry in turn; insert and pop rebuild the heap bottom-up, sifting down from each
// parent node in turn, and pop first shifts every later entry down by one place.
// The request side is not ready until the response beat is taken.
`default_nettype none
`include "assert_macros.svh"
module binary_max_heap_queue import bmhq_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    bmhq_req_if.sink req,
    bmhq_rsp_if.source rsp
);
    state_t state_reg, state_next;
    cnt_t count_reg, count_next;
    cnt_t i_reg, i_next;
    cnt_t p_reg, p_next;
    cnt_t at_reg, at_next;
    cnt_t big_reg, big_next;
    value_t v_reg, v_next;
    value_t atv_reg, atv_next;
    value_t bigv_reg, bigv_next;
    logic [1:0] status_reg, status_next;
    idx_t found_reg, found_next;
    value_t top_reg, top_next;

    logic we;
    idx_t waddr, raddr;
    value_t wdata, rdata;

    bmhq_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

    logic [CNT_W:0] lidx, ridx;
    assign lidx = {at_reg, 1'b1};
    assign ridx = {at_reg, 1'b0} + (CNT_W+1)'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        p_reg <= p_next;
        at_reg <= at_next;
        big_reg <= big_next;
        v_reg <= v_next;
        atv_reg <= atv_next;
        bigv_reg <= bigv_next;
        status_reg <= status_next;
        found_reg <= found_next;
        top_reg <= top_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next = i_reg;
        p_next = p_reg;
        at_next = at_reg;
        big_next = big_reg;
        v_next = v_reg;
        atv_next = atv_reg;
        bigv_next = bigv_reg;
        status_next = status_reg;
        found_next = found_reg;
        top_next = top_reg;
        we = 1'b0;
        waddr = '0;
        wdata = v_reg;
        raddr = '0;
        req.ready = (state_reg == S_IDLE);
        rsp.valid = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    v_next = req.value;
                    status_next = ST_OK;
                    found_next = '0;
                    i_next = '0;
                    case (req.kind)
                        KIND_INSERT:
                        begin
                            if (count_reg >= cnt_t'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                state_next = S_TOP_RD;
                            end
                            else
                            begin
                                we = 1'b1;
                                waddr = count_reg[IDX_W-1:0];
                                wdata = req.value;
                                count_next = count_reg + cnt_t'(1);
                                p_next = (count_reg + cnt_t'(1)) >> 1;
                                state_next = S_PARENT;
                            end
                        end
                        KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next = S_TOP_RD;
                            end
                            else
                            begin
                                i_next = '0;
                                state_next = S_SHIFT_RD;
                            end
                        end
                        KIND_FIND:
                        begin
                            status_next = ST_NOTFOUND;
                            state_next = S_FIND_RD;
                        end
                        default:
                        begin
                            state_next = S_TOP_RD;
                        end
                    endcase
                end
            end
            S_SHIFT_RD:
            begin
                if (i_reg + cnt_t'(1) < count_reg)
                begin
                    raddr = idx_t'(i_reg + cnt_t'(1));
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    count_next = count_reg - cnt_t'(1);
                    p_next = (count_reg - cnt_t'(1)) >> 1;
                    state_next = S_PARENT;
                end
            end
            S_SHIFT_WR:
            begin
                we = 1'b1;
                waddr = i_reg[IDX_W-1:0];
                wdata = rdata;
                i_next = i_reg + cnt_t'(1);
                state_next = S_SHIFT_RD;
            end
            S_FIND_RD:
            begin
                if (i_reg < count_reg)
                begin
                    raddr = i_reg[IDX_W-1:0];
                    state_next = S_FIND_CMP;
                end
                else
                begin
                    state_next = S_TOP_RD;
                end
            end
            S_FIND_CMP:
            begin
                if (rdata == v_reg)
                begin
                    status_next = ST_OK;
                    found_next = i_reg[IDX_W-1:0];
                    state_next = S_TOP_RD;
                end
                else
                begin
                    i_next = i_reg + cnt_t'(1);
                    state_next = S_FIND_RD;
                end
            end
            S_PARENT:
            begin
                if (p_reg == '0)
                begin
                    state_next = S_TOP_RD;
                end
                else
                begin
                    p_next = p_reg - cnt_t'(1);
                    at_next = p_reg - cnt_t'(1);
                    raddr = idx_t'(p_reg - cnt_t'(1));
                    state_next = S_RD_AT;
                end
            end
            S_RD_AT:
            begin
                atv_next = rdata;
                bigv_next = rdata;
                big_next = at_reg;
                if (lidx < {1'b0, count_reg})
                begin
                    raddr = lidx[IDX_W-1:0];
                    state_next = S_RD_L;
                end
                else
                begin
                    state_next = S_PARENT;
                end
            end
            S_RD_L:
            begin
                if (rdata > bigv_reg)
                begin
                    bigv_next = rdata;
                    big_next = lidx[CNT_W-1:0];
                end
                if (ridx < {1'b0, count_reg})
                begin
                    raddr = ridx[IDX_W-1:0];
                    state_next = S_RD_R;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_RD_R:
            begin
                if (rdata > bigv_reg)
                begin
                    bigv_next = rdata;
                    big_next = ridx[CNT_W-1:0];
                end
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (big_reg == at_reg)
                begin
                    state_next = S_PARENT;
                end
                else
                begin
                    we = 1'b1;
                    waddr = at_reg[IDX_W-1:0];
                    wdata = bigv_reg;
                    state_next = S_SWAP_B;
                end
            end
            S_SWAP_B:
            begin
                we = 1'b1;
                waddr = big_reg[IDX_W-1:0];
                wdata = atv_reg;
                at_next = big_reg;
                state_next = S_SWAP_A;
            end
            S_SWAP_A:
            begin
                atv_next = atv_reg;
                bigv_next = atv_reg;
                big_next = at_reg;
                if (lidx < {1'b0, count_reg})
                begin
                    raddr = lidx[IDX_W-1:0];
                    state_next = S_RD_L;
                end
                else
                begin
                    state_next = S_PARENT;
                end
            end
            S_TOP_RD:
            begin
                raddr = '0;
                state_next = S_TOP_WAIT;
            end
            S_TOP_WAIT:
            begin
                top_next = (count_reg == '0) ? value_t'(0) : rdata;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.status = status_reg;
    assign rsp.found_index = 6'(found_reg);
    assign rsp.top_value = top_reg;
    assign rsp.count = 7'(count_reg);

    `ASSERT_IMPLY(a_ready_idle, clk, rst_n, req.ready, !rsp.valid, "ready while response pending")
    `ASSERT_IMPLY(a_count_cap, clk, rst_n, 1'b1, count_reg <= cnt_t'(CAPACITY), "count over capacity")
    `ASSERT_NEXT(a_hold, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.top_value),
        "response changed while stalled")
endmodule
`default_nettype wire
